FILE: rtl/sstg_pkg.sv
// shared constants and types for the scanline slice tear block
package sstg_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int PIXEL_BITS = 16;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ADDR_W     = COL_W + 1;
   localparam int WID_W      = COL_W + 1;
   localparam int PIX_W      = 4 * PIXEL_BITS;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [31:0] GOLD    = 32'h9E37_79B9;
   localparam logic [31:0] MIXB    = 32'h85EB_CA6B;
   localparam logic [31:0] LB_MUL1 = 32'h7FEB_352D;
   localparam logic [31:0] LB_MUL2 = 32'h846C_A68B;

   localparam logic [1:0] CMD_PIXEL = 2'd0;
   localparam logic [1:0] CMD_FRAME = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_SLICE_HEIGHT = 3'd1,
      REG_TEAR_DENSITY = 3'd2,
      REG_MAX_SHIFT    = 3'd3,
      REG_CHROMA_SPLIT = 3'd4,
      REG_SEED         = 3'd5,
      REG_HOLD_FRAMES  = 3'd6,
      REG_FRAME_NUMBER = 3'd7
   } reg_idx_type;

endpackage

FILE: rtl/scanline_slice_tear_glitch.sv
// scanline slice tear: line-buffered row delay with hashed horizontal tearing
//
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  command, red, green, blue, alpha
// rsp_      out        rsp_valid / rsp_stall  out_red, out_green, out_blue, out_alpha, end_of_row
// csr_      in/out     apb psel/penable       8 registers at byte address 4*index
//
// a request goes through three reduction steps, three reads of the single-port line store
// (center, red and blue column), the output step and the write while a previous row
// is held, and through the reduction steps and the write with no row held
// a flush with no row held is dropped in the idle state and yields no output
// a row end runs two 12-step remainders, plus four lowbias passes on the one shared
// 32x32 multiplier when its slice tears and two when it does not; frame start runs
// a 32-step divide and two more hashes; a column, shift or split at or beyond
// a narrowed width goes through a 12-step remainder per value
// reset is synchronous; the line store is not cleared
// a result waits in the output register while the next work goes on; only
// the output step holds while rsp_stall is high
module scanline_slice_tear_glitch
   import sstg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic [PIXEL_BITS-1:0] req_red,
   input  logic [PIXEL_BITS-1:0] req_green,
   input  logic [PIXEL_BITS-1:0] req_blue,
   input  logic [PIXEL_BITS-1:0] req_alpha,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIXEL_BITS-1:0] rsp_out_red,
   output logic [PIXEL_BITS-1:0] rsp_out_green,
   output logic [PIXEL_BITS-1:0] rsp_out_blue,
   output logic [PIXEL_BITS-1:0] rsp_out_alpha,
   output logic                  rsp_end_of_row,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_FDIV,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_RED,
      ST_RDIV,
      ST_CX,
      ST_RX,
      ST_BX,
      ST_OUT,
      ST_WR,
      ST_RP0,
      ST_RP1,
      ST_RP2,
      ST_RP3,
      ST_RP4,
      ST_RP5,
      ST_RP6,
      ST_RP7,
      ST_RM,
      ST_RMD,
      ST_RS,
      ST_RSD,
      HS_MIX1,
      HS_MUL1,
      HS_MIX2,
      HS_MUL2,
      HS_MIX3
   } state_type;

   // configuration registers
   logic [12:0] frame_width_ff;
   logic [8:0]  slice_height_ff;
   logic [24:0] tear_density_ff;
   logic [13:0] max_shift_ff;
   logic [10:0] chroma_split_ff;
   logic [13:0] seed_ff;
   logic [3:0]  hold_frames_ff;
   logic [31:0] frame_number_ff;

   // block state
   state_type        state_ff, ret_ff;
   logic [COL_W-1:0] column_count_ff;
   logic [7:0]       slice_row_count_ff;
   logic [15:0]      slice_index_ff;
   logic [31:0]      frame_hash_ff;
   logic [COL_W-1:0] row_shift_ff;
   logic [COL_W-1:0] row_split_ff;
   logic             prior_row_valid_ff;
   logic             write_bank_ff;

   // item and datapath registers
   logic [1:0]       cmd_ff;
   logic [PIX_W-1:0] pix_ff;
   logic             emit_ff;
   logic [1:0]       red_sel_ff;
   logic [COL_W-1:0] col_r_ff, rs_r_ff, sp_r_ff, cx_ff;
   logic [31:0]      x_ff, t_ff, h_ff;
   logic [63:0]      prod_ff;
   logic             neg_ff;
   logic [COL_W-1:0] q_ff, spv_ff;
   logic [PIXEL_BITS-1:0] green_ff, alpha_ff, red_ff;

   // shared remainder unit
   logic [31:0]      dvd_ff, quo_ff;
   logic [WID_W-1:0] dvs_ff, rem_ff;
   logic [5:0]       cnt_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] out_red_ff, out_green_ff, out_blue_ff, out_alpha_ff;
   logic                  out_eor_ff;

   // line store
   logic [PIX_W-1:0]  mem [2*MAX_WIDTH];
   logic [PIX_W-1:0]  rd_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;

   logic [WID_W-1:0]  w_eff;
   logic [8:0]        slice_eff;
   logic [3:0]        hold_eff;
   logic [WID_W-1:0]  col_next;
   logic              row_end;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       mul_p;
   logic [WID_W:0]    div_trial;
   logic [WID_W:0]    cx_sum, rx_sum, bx_sum;
   logic [COL_W-1:0]  cx_calc, rx_calc, bx_calc;
   logic [COL_W-1:0]  red_val;
   logic [23:0]       u_hi;
   logic [63:0]       round_sum;
   logic [2:0]        csr_idx;
   logic              csr_wr;

   assign w_eff = (frame_width_ff == '0) ? WID_W'(1) :
                  (frame_width_ff > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : frame_width_ff;
   assign slice_eff = (slice_height_ff == 9'd0) ? 9'd1 :
                      (slice_height_ff > 9'd256) ? 9'd256 : slice_height_ff;
   assign hold_eff  = (hold_frames_ff == 4'd0) ? 4'd1 : hold_frames_ff;

   assign col_next = {1'b0, column_count_ff} + WID_W'(1);
   assign row_end  = col_next >= w_eff;

   // the one multiplier, operands picked by the sequencer
   always_comb begin
      mul_a = x_ff;
      mul_b = GOLD;
      case (state_ff)
         HS_MUL1: mul_b = LB_MUL1;
         HS_MUL2: mul_b = LB_MUL2;
         ST_F1:   mul_a = {18'd0, seed_ff};
         ST_RP1:  mul_a = frame_hash_ff;
         ST_RP4:  mul_b = {18'd0, max_shift_ff};
         ST_RP7:  mul_b = {21'd0, chroma_split_ff};
         default: ;
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign div_trial = {rem_ff, dvd_ff[31]};
   assign u_hi      = x_ff[31:8];
   assign round_sum = prod_ff + 64'(1 << 27);

   // wrapped column arithmetic, all operands already below the width
   assign cx_sum  = {2'b0, col_r_ff} + {1'b0, w_eff} - {2'b0, rs_r_ff};
   assign cx_calc = (cx_sum >= {1'b0, w_eff}) ? COL_W'(cx_sum - {1'b0, w_eff})
                                               : COL_W'(cx_sum);
   assign rx_sum  = {2'b0, cx_ff} + {1'b0, w_eff} - {2'b0, sp_r_ff};
   assign rx_calc = (rx_sum >= {1'b0, w_eff}) ? COL_W'(rx_sum - {1'b0, w_eff})
                                               : COL_W'(rx_sum);
   assign bx_sum  = {2'b0, cx_ff} + {2'b0, sp_r_ff};
   assign bx_calc = (bx_sum >= {1'b0, w_eff}) ? COL_W'(bx_sum - {1'b0, w_eff})
                                               : COL_W'(bx_sum);

   always_comb begin
      case (red_sel_ff)
         2'd0:    red_val = column_count_ff;
         2'd1:    red_val = row_shift_ff;
         default: red_val = row_split_ff;
      endcase
   end

   always_comb begin
      rd_en   = 1'b1;
      case (state_ff)
         ST_CX:   rd_addr = {~write_bank_ff, cx_calc};
         ST_RX:   rd_addr = {~write_bank_ff, rx_calc};
         ST_BX:   rd_addr = {~write_bank_ff, bx_calc};
         default: begin
            rd_addr = '0;
            rd_en   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (state_ff == ST_WR && cmd_ff != CMD_FLUSH) begin
         mem[{write_bank_ff, col_r_ff}] <= pix_ff;
      end
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      case (reg_idx_type'(csr_idx))
         REG_FRAME_WIDTH:  csr_prdata = {19'd0, frame_width_ff};
         REG_SLICE_HEIGHT: csr_prdata = {23'd0, slice_height_ff};
         REG_TEAR_DENSITY: csr_prdata = {7'd0, tear_density_ff};
         REG_MAX_SHIFT:    csr_prdata = {18'd0, max_shift_ff};
         REG_CHROMA_SPLIT: csr_prdata = {21'd0, chroma_split_ff};
         REG_SEED:         csr_prdata = {18'd0, seed_ff};
         REG_HOLD_FRAMES:  csr_prdata = {28'd0, hold_frames_ff};
         REG_FRAME_NUMBER: csr_prdata = frame_number_ff;
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 13'd1920;
         slice_height_ff <= 9'd24;
         tear_density_ff <= 25'd5872026;
         max_shift_ff    <= 14'd1536;
         chroma_split_ff <= 11'd192;
         seed_ff         <= '0;
         hold_frames_ff  <= 4'd2;
         frame_number_ff <= '0;
      end else if (csr_wr) begin
         case (reg_idx_type'(csr_idx))
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[12:0];
            REG_SLICE_HEIGHT: slice_height_ff <= csr_pwdata[8:0];
            REG_TEAR_DENSITY: tear_density_ff <= csr_pwdata[24:0];
            REG_MAX_SHIFT:    max_shift_ff    <= csr_pwdata[13:0];
            REG_CHROMA_SPLIT: chroma_split_ff <= csr_pwdata[10:0];
            REG_SEED:         seed_ff         <= csr_pwdata[13:0];
            REG_HOLD_FRAMES:  hold_frames_ff  <= csr_pwdata[3:0];
            REG_FRAME_NUMBER: frame_number_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = out_red_ff;
   assign rsp_out_green  = out_green_ff;
   assign rsp_out_blue   = out_blue_ff;
   assign rsp_out_alpha  = out_alpha_ff;
   assign rsp_end_of_row = out_eor_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         ret_ff             <= ST_IDLE;
         column_count_ff    <= '0;
         slice_row_count_ff <= '0;
         slice_index_ff     <= '0;
         frame_hash_ff      <= '0;
         row_shift_ff       <= '0;
         row_split_ff       <= '0;
         prior_row_valid_ff <= 1'b0;
         write_bank_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         cnt_ff             <= '0;
      end else begin
         // the output step reloads the register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         // remainder unit steps whenever it has bits left
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 6'd1;
            dvd_ff <= {dvd_ff[30:0], 1'b0};
            if (div_trial >= {1'b0, dvs_ff}) begin
               rem_ff <= WID_W'(div_trial - {1'b0, dvs_ff});
               quo_ff <= {quo_ff[30:0], 1'b1};
            end else begin
               rem_ff <= WID_W'(div_trial);
               quo_ff <= {quo_ff[30:0], 1'b0};
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff     <= req_command;
                  pix_ff     <= {req_alpha, req_blue, req_green, req_red};
                  emit_ff    <= prior_row_valid_ff;
                  red_sel_ff <= 2'd0;
                  if (req_command == CMD_FLUSH && !prior_row_valid_ff) begin
                     state_ff <= ST_IDLE;
                  end else if (req_command == CMD_FRAME) begin
                     dvd_ff   <= frame_number_ff;
                     dvs_ff   <= WID_W'(hold_eff);
                     rem_ff   <= '0;
                     cnt_ff   <= 6'd32;
                     state_ff <= ST_FDIV;
                  end else begin
                     state_ff <= ST_RED;
                  end
               end
            end

            // frame hash: lowbias((seed*gold+1)*gold ^ lowbias(frame/hold))
            ST_FDIV: begin
               if (cnt_ff == '0) begin
                  x_ff     <= quo_ff;
                  ret_ff   <= ST_F1;
                  state_ff <= HS_MIX1;
               end
            end
            ST_F1: begin
               t_ff     <= x_ff;
               x_ff     <= mul_p[31:0] + 32'd1;
               state_ff <= ST_F2;
            end
            ST_F2: begin
               x_ff     <= mul_p[31:0] ^ t_ff;
               ret_ff   <= ST_F3;
               state_ff <= HS_MIX1;
            end
            ST_F3: begin
               frame_hash_ff      <= x_ff;
               slice_row_count_ff <= '0;
               slice_index_ff     <= '0;
               column_count_ff    <= '0;
               state_ff           <= ST_RED;
            end

            // bring column, shift and split below the current width
            ST_RED: begin
               if ({1'b0, red_val} >= w_eff) begin
                  dvd_ff   <= {red_val, (32 - COL_W)'(0)};
                  dvs_ff   <= w_eff;
                  rem_ff   <= '0;
                  cnt_ff   <= 6'(COL_W);
                  state_ff <= ST_RDIV;
               end else begin
                  case (red_sel_ff)
                     2'd0:    col_r_ff <= red_val;
                     2'd1:    rs_r_ff  <= red_val;
                     default: sp_r_ff  <= red_val;
                  endcase
                  red_sel_ff <= red_sel_ff + 2'd1;
                  if (red_sel_ff == 2'd2) begin
                     state_ff <= emit_ff ? ST_CX : ST_WR;
                  end
               end
            end
            ST_RDIV: begin
               if (cnt_ff == '0) begin
                  case (red_sel_ff)
                     2'd0:    col_r_ff <= COL_W'(rem_ff);
                     2'd1:    rs_r_ff  <= COL_W'(rem_ff);
                     default: sp_r_ff  <= COL_W'(rem_ff);
                  endcase
                  red_sel_ff <= red_sel_ff + 2'd1;
                  state_ff   <= (red_sel_ff == 2'd2) ? (emit_ff ? ST_CX : ST_WR) : ST_RED;
               end
            end

            // three reads of the held row: center, red, blue
            ST_CX: begin
               cx_ff    <= cx_calc;
               state_ff <= ST_RX;
            end
            ST_RX: begin
               green_ff <= rd_ff[2*PIXEL_BITS-1:PIXEL_BITS];
               alpha_ff <= rd_ff[4*PIXEL_BITS-1:3*PIXEL_BITS];
               state_ff <= ST_BX;
            end
            ST_BX: begin
               red_ff   <= rd_ff[PIXEL_BITS-1:0];
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  out_red_ff   <= red_ff;
                  out_green_ff <= green_ff;
                  out_blue_ff  <= rd_ff[3*PIXEL_BITS-1:2*PIXEL_BITS];
                  out_alpha_ff <= alpha_ff;
                  out_eor_ff   <= row_end;
                  state_ff     <= ST_WR;
               end
            end

            ST_WR: begin
               if (cmd_ff == CMD_FLUSH) begin
                  if (row_end) begin
                     column_count_ff    <= '0;
                     prior_row_valid_ff <= 1'b0;
                  end else begin
                     column_count_ff <= COL_W'(col_next);
                  end
                  state_ff <= ST_IDLE;
               end else if (row_end) begin
                  column_count_ff    <= '0;
                  write_bank_ff      <= ~write_bank_ff;
                  prior_row_valid_ff <= 1'b1;
                  state_ff           <= ST_RP0;
               end else begin
                  column_count_ff <= COL_W'(col_next);
                  state_ff        <= ST_IDLE;
               end
            end

            // slice hash h = lowbias(frame_hash*gold ^ lowbias(slice_index))
            ST_RP0: begin
               x_ff     <= {16'd0, slice_index_ff};
               ret_ff   <= ST_RP1;
               state_ff <= HS_MIX1;
            end
            ST_RP1: begin
               x_ff     <= mul_p[31:0] ^ x_ff;
               ret_ff   <= ST_RP2;
               state_ff <= HS_MIX1;
            end
            ST_RP2: begin
               h_ff <= x_ff;
               if ({1'b0, u_hi} < tear_density_ff) begin
                  x_ff     <= x_ff ^ GOLD;
                  ret_ff   <= ST_RP3;
                  state_ff <= HS_MIX1;
               end else begin
                  neg_ff   <= 1'b0;
                  q_ff     <= '0;
                  spv_ff   <= '0;
                  state_ff <= ST_RM;
               end
            end
            ST_RP3: begin
               // magnitude of 2*u2 - 2^24 with its sign
               neg_ff <= ~u_hi[23];
               x_ff   <= u_hi[23] ? {7'd0, u_hi, 1'b0} - 32'h0100_0000
                                  : 32'h0100_0000 - {7'd0, u_hi, 1'b0};
               state_ff <= ST_RP4;
            end
            ST_RP4: begin
               prod_ff  <= mul_p;
               state_ff <= ST_RP5;
            end
            ST_RP5: begin
               q_ff     <= round_sum[28 +: COL_W];
               x_ff     <= h_ff ^ MIXB;
               ret_ff   <= ST_RP6;
               state_ff <= HS_MIX1;
            end
            ST_RP6: begin
               x_ff     <= {8'd0, u_hi};
               state_ff <= ST_RP7;
            end
            ST_RP7: begin
               // x_ff holds u3, the shared multiplier scales it by the chroma split
               prod_ff  <= mul_p;
               state_ff <= ST_RM;
               spv_ff   <= '0;
            end
            ST_RM: begin
               if (ret_ff == ST_RP6) begin
                  spv_ff <= round_sum[28 +: COL_W];
               end
               dvd_ff   <= {q_ff, (32 - COL_W)'(0)};
               dvs_ff   <= w_eff;
               rem_ff   <= '0;
               cnt_ff   <= 6'(COL_W);
               state_ff <= ST_RMD;
            end
            ST_RMD: begin
               if (cnt_ff == '0) begin
                  row_shift_ff <= (neg_ff && rem_ff != '0) ? COL_W'(w_eff - rem_ff)
                                                           : COL_W'(rem_ff);
                  state_ff     <= ST_RS;
               end
            end
            ST_RS: begin
               dvd_ff   <= {spv_ff, (32 - COL_W)'(0)};
               dvs_ff   <= w_eff;
               rem_ff   <= '0;
               cnt_ff   <= 6'(COL_W);
               state_ff <= ST_RSD;
            end
            ST_RSD: begin
               if (cnt_ff == '0) begin
                  row_split_ff <= COL_W'(rem_ff);
                  if ({1'b0, slice_row_count_ff} + 9'd1 >= slice_eff) begin
                     slice_row_count_ff <= '0;
                     slice_index_ff     <= slice_index_ff + 16'd1;
                  end else begin
                     slice_row_count_ff <= slice_row_count_ff + 8'd1;
                  end
                  ret_ff   <= ST_IDLE;
                  state_ff <= ST_IDLE;
               end
            end

            // lowbias32 on x_ff, returns to ret_ff
            HS_MIX1: begin
               x_ff     <= x_ff ^ (x_ff >> 16);
               state_ff <= HS_MUL1;
            end
            HS_MUL1: begin
               x_ff     <= mul_p[31:0];
               state_ff <= HS_MIX2;
            end
            HS_MIX2: begin
               x_ff     <= x_ff ^ (x_ff >> 15);
               state_ff <= HS_MUL2;
            end
            HS_MUL2: begin
               x_ff     <= mul_p[31:0];
               state_ff <= HS_MIX3;
            end
            HS_MIX3: begin
               x_ff     <= x_ff ^ (x_ff >> 16);
               state_ff <= ret_ff;
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: dv/tb_top.sv
// testbench for the scanline slice tear block: random pixel rows checked against a row-delay predictor
`timescale 1ns / 1ps

module tb_top;
   import sstg_pkg::*;

   // command code 3 has no name in the package; the block treats it as a plain pixel
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int unsigned DENS_ONE = 32'd16777216;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
   } pixel_req_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
      logic        eor;
   } torn_pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_command;
   logic [PIXEL_BITS-1:0] req_red, req_green, req_blue, req_alpha;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PIXEL_BITS-1:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic                  rsp_end_of_row;
   logic                  csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   scanline_slice_tear_glitch u_dut (.*);

   // pixel requests waiting for the driver, and predicted output pixels in order
   pixel_req_type  pending_px_q[$];
   torn_pixel_type torn_px_q[$];

   int unsigned n_pushed, n_taken, n_out, n_err, n_phases;
   bit          req_taken;
   bit          calm;

   // predictor copy of the register file
   int unsigned p_width, p_slice, p_density, p_max_shift, p_split_max;
   int unsigned p_seed, p_hold, p_frame_num;

   // predictor copy of the datapath state
   logic [63:0] line_mem [2*MAX_WIDTH];
   int unsigned col_cnt, slice_row, slice_idx, frame_key;
   int unsigned row_shift, row_split, row_held, wr_bank;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // generous fixed limit: a clean run needs a few milliseconds even with long stalls
   initial begin
      #20ms;
      $display("tb_top: done, errors");
      $finish;
   end

   function automatic logic [31:0] lowbias32(logic [31:0] x);
      x = x ^ (x >> 16);
      x = x * 32'h7feb352d;
      x = x ^ (x >> 15);
      x = x * 32'h846ca68b;
      x = x ^ (x >> 16);
      return x;
   endfunction

   function automatic logic [31:0] mix_pair(logic [31:0] a, logic [31:0] b);
      logic [31:0] prod;
      prod = a * 32'h9E3779B9;
      return lowbias32(prod ^ lowbias32(b));
   endfunction

   function automatic int unsigned clamped_width();
      if (p_width == 0) return 1;
      if (p_width > MAX_WIDTH) return MAX_WIDTH;
      return p_width;
   endfunction

   function automatic int unsigned clamped_slice();
      if (p_slice == 0) return 1;
      if (p_slice > 256) return 256;
      return p_slice;
   endfunction

   // per-row tear decision: shift and split, rounded half away from zero, then wrapped
   function automatic void latch_row_tear(int unsigned w);
      logic [31:0] h;
      longint u2, n, m, q, sh, r;
      longint unsigned u3, sp;
      h  = mix_pair(frame_key, slice_idx);
      sh = 0;
      sp = 0;
      if ((h >> 8) < p_density) begin
         u2 = longint'(lowbias32(h ^ 32'h9E3779B9) >> 8);
         n  = (2 * u2 - 16777216) * longint'(p_max_shift);
         m  = (n < 0) ? -n : n;
         q  = (m + (64'd1 << 27)) >>> 28;
         sh = (n < 0) ? -q : q;
         u3 = longint'(lowbias32(h ^ 32'h85EBCA6B) >> 8);
         sp = (u3 * p_split_max + (64'd1 << 27)) >> 28;
      end
      r = sh % longint'(w);
      if (r < 0) r += longint'(w);
      row_shift = int'(r) & 12'hFFF;
      row_split = int'(sp % w) & 12'hFFF;
   endfunction

   function automatic torn_pixel_type read_torn(int unsigned w, int unsigned col);
      torn_pixel_type o;
      int unsigned base, c, rs, sp, cx, rx, bx;
      base = (wr_bank ^ 1) * MAX_WIDTH;
      c  = col % w;
      rs = row_shift % w;
      sp = row_split % w;
      cx = (c + w - rs) % w;
      rx = (cx + w - sp) % w;
      bx = (cx + sp) % w;
      o.red   = line_mem[base + rx][15:0];
      o.green = line_mem[base + cx][31:16];
      o.blue  = line_mem[base + bx][47:32];
      o.alpha = line_mem[base + cx][63:48];
      o.eor   = (col + 1 >= w);
      return o;
   endfunction

   function automatic void predict_torn(pixel_req_type px);
      int unsigned w, hold;
      w = clamped_width();
      if (px.cmd == CMD_FLUSH) begin
         if (row_held != 0) begin
            torn_px_q = {torn_px_q, read_torn(w, col_cnt)};
            if (col_cnt + 1 >= w) begin
               col_cnt  = 0;
               row_held = 0;
            end else begin
               col_cnt++;
            end
         end
         return;
      end
      if (px.cmd == CMD_FRAME) begin
         hold      = (p_hold == 0) ? 1 : p_hold;
         frame_key = mix_pair(p_seed * 32'h9E3779B9 + 32'd1, p_frame_num / hold);
         slice_row = 0;
         slice_idx = 0;
         col_cnt   = 0;
      end
      if (row_held != 0) torn_px_q = {torn_px_q, read_torn(w, col_cnt)};
      line_mem[wr_bank * MAX_WIDTH + (col_cnt % w)] = {px.alpha, px.blue, px.green, px.red};
      if (col_cnt + 1 >= w) begin
         col_cnt  = 0;
         wr_bank ^= 1;
         row_held = 1;
         latch_row_tear(w);
         if (slice_row + 1 >= clamped_slice()) begin
            slice_row = 0;
            slice_idx = (slice_idx + 1) & 16'hFFFF;
         end else begin
            slice_row++;
         end
      end else begin
         col_cnt++;
      end
   endfunction

   // mostly short gaps, a few long ones, none while in a calm stretch
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (calm) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 20);
      return $urandom_range(30, 120);
   endfunction

   // request driver: new values at the falling edge only
   int unsigned req_gap;
   always @(negedge clock) begin
      pixel_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   = 0;
      end else if (req_valid && !req_taken) begin
         // stalled request holds its payload
      end else if (req_gap > 0) begin
         req_gap--;
         req_valid <= 1'b0;
      end else if (pending_px_q.size() > 0) begin
         nxt = pending_px_q.pop_front();
         req_valid   <= 1'b1;
         req_command <= nxt.cmd;
         req_red     <= nxt.red;
         req_green   <= nxt.green;
         req_blue    <= nxt.blue;
         req_alpha   <= nxt.alpha;
         req_gap     = pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // output back-pressure, also switched at the falling edge
   int unsigned stall_left;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // calm stretches with no idling on either side
   initial begin
      calm = 1'b0;
      forever begin
         repeat ($urandom_range(200, 2000)) @(posedge clock);
         calm = ~calm;
      end
   end

   // monitor and acceptance: check results first, then predict for the accepted request
   always @(posedge clock) begin
      torn_pixel_type want;
      pixel_req_type  got_req;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_out++;
            if (torn_px_q.size() == 0) begin
               $error("output pixel with nothing expected");
               n_err++;
            end else begin
               want = torn_px_q.pop_front();
               if (rsp_out_red !== want.red) begin
                  $error("out_red exp %h got %h", want.red, rsp_out_red);
                  n_err++;
               end
               if (rsp_out_green !== want.green) begin
                  $error("out_green exp %h got %h", want.green, rsp_out_green);
                  n_err++;
               end
               if (rsp_out_blue !== want.blue) begin
                  $error("out_blue exp %h got %h", want.blue, rsp_out_blue);
                  n_err++;
               end
               if (rsp_out_alpha !== want.alpha) begin
                  $error("out_alpha exp %h got %h", want.alpha, rsp_out_alpha);
                  n_err++;
               end
               if (rsp_end_of_row !== want.eor) begin
                  $error("end_of_row exp %b got %b", want.eor, rsp_end_of_row);
                  n_err++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken     = 1'b1;
            got_req.cmd   = req_command;
            got_req.red   = req_red;
            got_req.green = req_green;
            got_req.blue  = req_blue;
            got_req.alpha = req_alpha;
            predict_torn(got_req);
            n_taken++;
         end
      end
   end

   // apb write: setup cycle, then access cycle; pready is tied high in the block
   task automatic csr_write(reg_idx_type idx, logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_FRAME_WIDTH:  p_width     = val & 32'h1FFF;
         REG_SLICE_HEIGHT: p_slice     = val & 32'h1FF;
         REG_TEAR_DENSITY: p_density   = val & 32'h1FFFFFF;
         REG_MAX_SHIFT:    p_max_shift = val & 32'h3FFF;
         REG_CHROMA_SPLIT: p_split_max = val & 32'h7FF;
         REG_SEED:         p_seed      = val & 32'h3FFF;
         REG_HOLD_FRAMES:  p_hold      = val & 32'hF;
         REG_FRAME_NUMBER: p_frame_num = val;
         default: ;
      endcase
   endtask

   task automatic write_all_regs(logic [31:0] w, logic [31:0] sl, logic [31:0] dens,
                                 logic [31:0] ms, logic [31:0] cs, logic [31:0] sd,
                                 logic [31:0] hold, logic [31:0] fnum);
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_SLICE_HEIGHT, sl);
      csr_write(REG_TEAR_DENSITY, dens);
      csr_write(REG_MAX_SHIFT, ms);
      csr_write(REG_CHROMA_SPLIT, cs);
      csr_write(REG_SEED, sd);
      csr_write(REG_HOLD_FRAMES, hold);
      csr_write(REG_FRAME_NUMBER, fnum);
      n_phases++;
   endtask

   function automatic logic [15:0] rand_chan();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) return 16'h0000;
      if (roll == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic void push_px(logic [1:0] cmd);
      pixel_req_type px;
      px.cmd   = cmd;
      px.red   = rand_chan();
      px.green = rand_chan();
      px.blue  = rand_chan();
      px.alpha = rand_chan();
      pending_px_q = {pending_px_q, px};
      n_pushed++;
   endfunction

   function automatic void push_plain(int unsigned count);
      repeat (count) push_px(($urandom_range(9) == 0) ? CMD_SPARE : CMD_PIXEL);
   endfunction

   // both line banks filled at the current width, so later reads never hit stale columns
   function automatic void push_prime(int unsigned w);
      push_px(CMD_FRAME);
      push_plain(2 * w - 1);
   endfunction

   // enough flushes to empty a held row; extra ones are ignored by the block
   function automatic void push_drain(int unsigned w);
      repeat (w) push_px(CMD_FLUSH);
   endfunction

   // idle means every request taken and every output seen, plus slack for
   // row-end hashing and frame-start divide that may still be running
   task automatic wait_idle();
      while (n_taken != n_pushed || torn_px_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic void push_random_rows(int unsigned w);
      int unsigned rows, cut;
      rows = $urandom_range(2, 6);
      repeat (rows) begin
         case ($urandom_range(9))
            0: begin
               // frame restart partway through a row
               cut = $urandom_range(0, w - 1);
               push_plain(cut);
               push_px(CMD_FRAME);
               push_plain(w - 1);
            end
            1: begin
               // flush burst dropped into the middle of a row
               cut = $urandom_range(0, w - 1);
               push_plain(cut);
               repeat ($urandom_range(1, 3)) push_px(CMD_FLUSH);
               push_plain(w - cut);
            end
            2: begin
               push_px(CMD_FRAME);
               push_plain(w - 1);
            end
            default: push_plain(w);
         endcase
      end
   endfunction

   initial begin
      int unsigned w, sl, dens, ms, cs;
      reset       = 1'b1;
      req_command = CMD_PIXEL;
      req_red     = '0;
      req_green   = '0;
      req_blue    = '0;
      req_alpha   = '0;
      rsp_stall   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      stall_left  = 0;
      n_pushed = 0; n_taken = 0; n_out = 0; n_err = 0; n_phases = 0;
      p_width = 1920; p_slice = 24; p_density = 5872026; p_max_shift = 1536;
      p_split_max = 192; p_seed = 0; p_hold = 2; p_frame_num = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
      col_cnt = 0; slice_row = 0; slice_idx = 0; frame_key = 0;
      row_shift = 0; row_split = 0; row_held = 0; wr_bank = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every slice tears, with max shift 0x2000 and chroma split 0x400
      write_all_regs(4, 1, 32'h1FFFFFF, 32'h2000, 32'h400, 0, 1, 0);
      push_px(CMD_FLUSH);                  // flush with no row held: nothing out
      push_prime(4);
      begin
         pixel_req_type px;
         px = '{cmd: CMD_PIXEL, red: 16'hFFFF, green: 16'h0000, blue: 16'hFFFF,
                alpha: 16'h0000};
         pending_px_q = {pending_px_q, px};
         px = '{cmd: CMD_SPARE, red: 16'h0000, green: 16'hFFFF, blue: 16'h0000,
                alpha: 16'hFFFF};
         pending_px_q = {pending_px_q, px};
         n_pushed += 2;
      end
      push_px(CMD_FRAME);                  // frame start mid-row
      push_plain(3);
      push_plain(1);
      push_px(CMD_FLUSH);                  // flush mid-row while a row is held
      push_plain(3);
      push_drain(4);
      wait_idle();

      // directed: zero width acts as one, never tears, hold of zero
      write_all_regs(0, 0, 0, 0, 0, 32'h3FFF, 0, 32'hFFFFFFFF);
      push_prime(1);
      push_plain(4);
      push_px(CMD_FRAME);
      push_drain(1);
      wait_idle();

      // random phases, narrow rows mostly
      while (n_pushed < 820) begin
         case ($urandom_range(19))
            0:  w = $urandom_range(17, 32);
            1, 2, 3, 4, 5: w = $urandom_range(9, 16);
            default: w = $urandom_range(1, 8);
         endcase
         sl = ($urandom_range(1) == 0) ? $urandom_range(1, 4) : $urandom_range(0, 511);
         case ($urandom_range(4))
            0: dens = 0;
            1: dens = DENS_ONE;
            2: dens = 32'h1FFFFFF;
            default: dens = $urandom_range(0, DENS_ONE);
         endcase
         ms = ($urandom_range(3) == 0) ? 32'h3FFF : $urandom_range(0, 16383);
         cs = ($urandom_range(3) == 0) ? 32'h7FF : $urandom_range(0, 2047);
         write_all_regs(w, sl, dens, ms, cs, $urandom_range(0, 16383),
                        $urandom_range(0, 15), $urandom);
         push_prime(w);
         push_random_rows(w);
         push_drain(w);
         wait_idle();
      end

      $display("covered %0d phases, %0d requests taken, %0d pixels out",
               n_phases, n_taken, n_out);
      $display("widths from clamped zero up to 32, tear density off to saturated");
      if (n_err == 0 && torn_px_q.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sstg_pkg.sv
rtl/scanline_slice_tear_glitch.sv
dv/tb_top.sv
